/* hdl/isotp_pkg.sv */
// ---------------------------------------------------------------------------
// ISO-TP receive reassembly package
// Request and response payload types, event and flow-control codes.
// ---------------------------------------------------------------------------
package isotp_pkg;

   localparam int unsigned CAN_ID_W   = 29;
   localparam int unsigned FRAME_LEN_W = 4;
   localparam int unsigned FRAME_W    = 64;
   localparam int unsigned PAYLOAD_W  = 56;
   localparam int unsigned PLEN_W     = 3;
   localparam int unsigned TARGET_W   = 12;
   localparam int unsigned COUNT_W    = 13;
   localparam int unsigned SEQ_W      = 4;

   // Protocol control codes (upper nibble of byte 0).
   localparam logic [3:0] PCI_SINGLE = 4'h0;
   localparam logic [3:0] PCI_FIRST  = 4'h1;
   localparam logic [3:0] PCI_CONSEC = 4'h2;

   localparam logic [3:0] MAX_FRAME_LEN = 4'd8;

   localparam logic [2:0] EV_IGNORED     = 3'd0;
   localparam logic [2:0] EV_SINGLE_DONE = 3'd1;
   localparam logic [2:0] EV_FIRST_START = 3'd2;
   localparam logic [2:0] EV_FIRST_DONE  = 3'd3;
   localparam logic [2:0] EV_CONSEC_OK   = 3'd4;
   localparam logic [2:0] EV_CONSEC_DONE = 3'd5;
   localparam logic [2:0] EV_SEQ_ERROR   = 3'd6;
   localparam logic [2:0] EV_SHORT_FIRST = 3'd7;

   localparam logic [1:0] FLOW_NONE  = 2'd0;
   localparam logic [1:0] FLOW_CTS   = 2'd1;
   localparam logic [1:0] FLOW_ABORT = 2'd2;

   typedef struct packed {
      logic [FRAME_W-1:0]     frame_bytes;
      logic [FRAME_LEN_W-1:0] frame_len;
      logic [CAN_ID_W-1:0]    frame_id;
   } req_type;

   typedef struct packed {
      logic [1:0]           flow_request;
      logic                 message_done;
      logic [COUNT_W-1:0]   received_count;
      logic [TARGET_W-1:0]  announced_length;
      logic [PLEN_W-1:0]    payload_len;
      logic [PAYLOAD_W-1:0] payload;
      logic [2:0]           event_res;
   } rsp_type;

   // Keep the low plen bytes of a 56-bit word, clear the rest.
   function automatic logic [PAYLOAD_W-1:0] keep_bytes(input logic [PAYLOAD_W-1:0] data,
                                                       input logic [PLEN_W-1:0] plen);
      logic [PAYLOAD_W-1:0] res;
      res = '0;
      for (int i = 0; i < PAYLOAD_W/8; i++) begin
         if (PLEN_W'(i) < plen) begin
            res[i*8 +: 8] = data[i*8 +: 8];
         end
      end
      return res;
   endfunction

endpackage

/* hdl/isotp_receive_reassembly_unit.sv */
// ---------------------------------------------------------------------------
// ISO-TP receive reassembly unit
// Decodes one CAN frame per request, tracks the multi-frame session and
// returns the frame's payload with an event code and a flow-control request.
// ---------------------------------------------------------------------------
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------
//   req     | in        | req_valid/req_ready  | req_data (req_type)
//   rsp     | out       | rsp_valid/rsp_ready  | rsp_data (rsp_type)
//   csr     | in        | csr_valid/csr_ready  | csr_data (session id)
//
// A request is registered, decoded against the session state and written to
// the response register. It sustains one request per cycle while the response
// is not stalled; the decode sits between the two registers. A stalled
// response holds the input register, which then holds req_ready low. Reset
// clears the valid flags, the session state and the id.
//
module isotp_receive_reassembly_unit
   import isotp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  req_type             req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_type             rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CAN_ID_W-1:0] csr_data
);

   logic                session_id_ff;
   logic [CAN_ID_W-1:0] session_id_reg_ff;
   req_type             req_ff;
   logic                req_valid_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_ff;

   logic                in_progress_ff, in_progress_in;
   logic [SEQ_W-1:0]    expected_sequence_ff, expected_sequence_in;
   logic [TARGET_W-1:0] target_length_ff, target_length_in;
   logic [COUNT_W-1:0]  byte_count_ff, byte_count_in;
   rsp_type             rsp_in;

   logic                advance;
   logic [3:0]          len;
   logic [7:0]          byte0;
   logic [3:0]          code;
   logic [3:0]          low;
   logic [PLEN_W-1:0]   plen;
   logic [PAYLOAD_W-1:0] shifted;
   logic [COUNT_W-1:0]  count_sum;
   logic [TARGET_W-1:0] first_target;

   assign csr_ready = 1'b1;
   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      len          = (req_ff.frame_len > MAX_FRAME_LEN) ? MAX_FRAME_LEN : req_ff.frame_len;
      byte0        = req_ff.frame_bytes[7:0];
      code         = byte0[7:4];
      low          = byte0[3:0];
      first_target = {low, req_ff.frame_bytes[15:8]};
      plen         = '0;
      shifted      = '0;
      count_sum    = '0;

      in_progress_in       = in_progress_ff;
      expected_sequence_in = expected_sequence_ff;
      target_length_in     = target_length_ff;
      byte_count_in        = byte_count_ff;

      rsp_in              = '0;
      rsp_in.event_res    = EV_IGNORED;
      rsp_in.flow_request = FLOW_NONE;

      if (req_ff.frame_id == session_id_reg_ff && len != 4'd0) begin
         case (code)
            PCI_SINGLE: begin
               if (len >= 4'd2 && ({1'b0, low} + 5'd1) <= {1'b0, len}) begin
                  plen                = low[PLEN_W-1:0];
                  shifted             = req_ff.frame_bytes[63:8];
                  rsp_in.event_res    = EV_SINGLE_DONE;
                  rsp_in.message_done = 1'b1;
               end
            end
            PCI_FIRST: begin
               if (!in_progress_ff) begin
                  if (len < 4'd2) begin
                     rsp_in.event_res    = EV_SHORT_FIRST;
                     rsp_in.flow_request = FLOW_ABORT;
                  end else begin
                     plen             = PLEN_W'(len - 4'd2);
                     shifted          = {8'h00, req_ff.frame_bytes[63:16]};
                     target_length_in = first_target;
                     byte_count_in    = COUNT_W'(plen);
                     if ({1'b0, first_target} <= COUNT_W'(plen)) begin
                        rsp_in.event_res    = EV_FIRST_DONE;
                        rsp_in.message_done = 1'b1;
                     end else begin
                        rsp_in.event_res     = EV_FIRST_START;
                        rsp_in.flow_request  = FLOW_CTS;
                        in_progress_in       = 1'b1;
                        expected_sequence_in = SEQ_W'(1);
                     end
                  end
               end
            end
            PCI_CONSEC: begin
               if (in_progress_ff && len >= 4'd2) begin
                  if (low != expected_sequence_ff) begin
                     rsp_in.event_res = EV_SEQ_ERROR;
                     in_progress_in   = 1'b0;
                  end else begin
                     // Sequence number wraps from 15 to 0.
                     expected_sequence_in = expected_sequence_ff + SEQ_W'(1);
                     plen                 = PLEN_W'(len - 4'd1);
                     shifted              = req_ff.frame_bytes[63:8];
                     count_sum            = byte_count_ff + COUNT_W'(plen);
                     byte_count_in        = count_sum;
                     if (count_sum >= {1'b0, target_length_ff}) begin
                        rsp_in.event_res    = EV_CONSEC_DONE;
                        rsp_in.message_done = 1'b1;
                        in_progress_in      = 1'b0;
                     end else begin
                        rsp_in.event_res = EV_CONSEC_OK;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end

      rsp_in.payload          = keep_bytes(shifted, plen);
      rsp_in.payload_len      = plen;
      rsp_in.announced_length = target_length_in;
      rsp_in.received_count   = byte_count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff         <= 1'b0;
         rsp_valid_ff         <= 1'b0;
         session_id_ff        <= 1'b0;
         session_id_reg_ff    <= '0;
         in_progress_ff       <= 1'b0;
         expected_sequence_ff <= '0;
         target_length_ff     <= '0;
         byte_count_ff        <= '0;
      end else begin
         if (csr_valid) begin
            session_id_reg_ff <= csr_data;
            session_id_ff     <= 1'b1;
         end
         if (req_ready) begin
            req_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff         <= 1'b1;
            in_progress_ff       <= in_progress_in;
            expected_sequence_ff <= expected_sequence_in;
            target_length_ff     <= target_length_in;
            byte_count_ff        <= byte_count_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   // A written session id never changes the reset-cleared flag back.
   a_csr_flag: assert property (@(posedge clock) disable iff (reset)
      session_id_ff |=> session_id_ff)
      else $error("session id written flag dropped");

   a_done_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.message_done |->
         (rsp_data.event_res == EV_SINGLE_DONE || rsp_data.event_res == EV_FIRST_DONE ||
          rsp_data.event_res == EV_CONSEC_DONE))
      else $error("message done with a non-completing event");

   a_abort_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.flow_request == FLOW_ABORT |->
         rsp_data.event_res == EV_SHORT_FIRST)
      else $error("abort requested without a short first frame");

   a_seq_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.event_res == EV_SEQ_ERROR |->
         rsp_data.payload_len == '0 && !in_progress_ff)
      else $error("sequence error left payload or session open");

   a_advance: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("decoded request did not reach the response register");

endmodule
